// ===== src/cs_pkg.sv =====
// Shared types, constants and bit-count helpers for the successor block.
package cs_pkg;

  localparam int VEC_W = 32;
  localparam int CNT_W = 6;
  localparam int MIN_W = 2;
  localparam logic [CNT_W-1:0] RESET_WIDTH = 6'd32;

  typedef logic [VEC_W-1:0] vec_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    vec_t next_value;
    cnt_t next_weight;
    logic weight_increased;
    logic wrapped;
  } succ_t;

  // n low bits set; n of VEC_W or more gives all ones
  function automatic vec_t low_ones(input cnt_t n);
    logic [VEC_W:0] wide;
    wide = ({{VEC_W{1'b0}}, 1'b1} << n) - {{VEC_W{1'b0}}, 1'b1};
    return wide[VEC_W-1:0];
  endfunction

  function automatic cnt_t popcount(input vec_t x);
    cnt_t c;
    c = '0;
    for (int i = 0; i < VEC_W; i++) begin
      c = c + cnt_t'(x[i]);
    end
    return c;
  endfunction

endpackage

// ===== src/cs_vec_if.sv =====
// Handshake channel carrying one input bit vector per beat.
interface cs_vec_if;
  logic           valid;
  logic           ready;
  cs_pkg::vec_t   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== src/cs_succ_if.sv =====
// Handshake channel carrying one successor result per beat.
interface cs_succ_if;
  logic           valid;
  logic           ready;
  cs_pkg::vec_t   next_value;
  cs_pkg::cnt_t   next_weight;
  logic           weight_increased;
  logic           wrapped;

  modport source (output valid, output next_value, output next_weight,
                  output weight_increased, output wrapped, input ready);
  modport sink   (input valid, input next_value, input next_weight,
                  input weight_increased, input wrapped, output ready);
endinterface

// ===== src/cs_step.sv =====
// Combinational successor: moves the lowest movable bit up and repacks the run below it, else grows or wraps.
module cs_step (
  input  cs_pkg::vec_t  v,
  input  cs_pkg::cnt_t  w,
  output cs_pkg::succ_t res
);
  import cs_pkg::*;

  vec_t movable;
  vec_t lsb;
  vec_t run_mask;
  vec_t top_bit;
  vec_t moved;
  vec_t grow;
  cnt_t weight;
  cnt_t run_len;
  logic can_move;
  logic full;

  // a set bit whose upper neighbor is clear; bit w-1 sees a clear bit above
  assign movable  = v & ~(v >> 1);
  assign lsb      = movable & (~movable + VEC_W'(1));
  // bits 0..pos; v holds one contiguous run ending at pos inside it
  assign run_mask = lsb | (lsb - VEC_W'(1));
  assign top_bit  = VEC_W'(1) << (w - CNT_W'(1));
  assign can_move = (movable != '0) && ((lsb & top_bit) == '0);
  assign run_len  = popcount(v & run_mask);
  assign moved    = (v & ~run_mask) | (lsb << 1) | low_ones(run_len - CNT_W'(1));
  assign weight   = popcount(v);
  assign full     = (weight == w);
  assign grow     = low_ones(weight + CNT_W'(1));

  always_comb begin
    if (can_move) begin
      res = '{next_value: moved, next_weight: weight,
              weight_increased: 1'b0, wrapped: 1'b0};
    end else if (full) begin
      res = '{next_value: '0, next_weight: '0,
              weight_increased: 1'b0, wrapped: 1'b1};
    end else begin
      res = '{next_value: grow, next_weight: weight + CNT_W'(1),
              weight_increased: 1'b1, wrapped: 1'b0};
    end
  end

endmodule

// ===== src/chord_successor.sv =====
// Successor of a bit vector in weight-then-combination order.
//
// vec carries one input vector per beat; succ returns one result beat per
// input beat, in order: the successor vector, its bit count, a flag when
// the count grew and a flag when an all-ones vector wrapped to zero.
// cfg_we/cfg_wdata write width_in_use, the number of low bits in use; it is
// saturated to 2..min(WIDTH,32) and bits above it are ignored. Write it only
// while no beat is in flight.
// A beat goes into the input register, then through the successor logic
// (bit isolate plus two bit counts) into the result register, which drives
// succ. Throughput is one beat per cycle while succ is not stalled.
// When succ is stalled the result register holds and the input register
// still takes one more beat; vec.ready drops only when both are full.
// rst (synchronous) empties both stages and sets width_in_use to 32.
module chord_successor #(
  parameter int WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  cs_pkg::cnt_t        cfg_wdata,
  cs_vec_if.sink              vec,
  cs_succ_if.source           succ
);
  import cs_pkg::*;

  localparam int MAX_W = (WIDTH < VEC_W) ? WIDTH : VEC_W;

  cnt_t  width_in_use;
  cnt_t  eff_w;
  logic  s1_valid;
  vec_t  s1_vec;
  logic  out_valid;
  succ_t out_res;
  succ_t step_res;
  logic  out_take;
  logic  s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use <= RESET_WIDTH;
    end else if (cfg_we) begin
      width_in_use <= cfg_wdata;
    end
  end

  always_comb begin
    if (width_in_use < CNT_W'(MIN_W)) begin
      eff_w = CNT_W'(MIN_W);
    end else if (width_in_use > CNT_W'(MAX_W)) begin
      eff_w = CNT_W'(MAX_W);
    end else begin
      eff_w = width_in_use;
    end
  end

  assign out_take  = !out_valid || succ.ready;
  assign s1_take   = !s1_valid || out_take;
  assign vec.ready = s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid <= vec.valid;
      end
      if (out_take) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && vec.valid) begin
      s1_vec <= vec.value & low_ones(eff_w);
    end
    if (out_take && s1_valid) begin
      out_res <= step_res;
    end
  end

  cs_step u_step (
    .v   (s1_vec),
    .w   (eff_w),
    .res (step_res)
  );

  assign succ.valid            = out_valid;
  assign succ.next_value       = out_res.next_value;
  assign succ.next_weight      = out_res.next_weight;
  assign succ.weight_increased = out_res.weight_increased;
  assign succ.wrapped          = out_res.wrapped;

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !succ.valid)
    else $error("result valid right after reset");

  a_wrap_zero: assert property (@(posedge clk) disable iff (rst)
    succ.valid && succ.wrapped |->
      succ.next_value == '0 && succ.next_weight == '0 && !succ.weight_increased)
    else $error("wrap beat with nonzero payload");

  a_grow_low: assert property (@(posedge clk) disable iff (rst)
    succ.valid && succ.weight_increased |->
      succ.next_value == low_ones(succ.next_weight))
    else $error("grown weight is not the lowest bits set");

  a_weight_match: assert property (@(posedge clk) disable iff (rst)
    succ.valid |-> popcount(succ.next_value) == succ.next_weight)
    else $error("weight does not match vector");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    succ.valid && !succ.ready && s1_valid |-> !vec.ready)
    else $error("input taken with both stages full");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_take |=> succ.valid)
    else $error("beat lost between stages");

endmodule
